// ----- hw/rtl/vibe_pkg.sv -----
// ----------------------------------------------------------------------------
// ViBe pixel classifier package
// Register indexes, operation codes and the neighbor offset table.
// ----------------------------------------------------------------------------
package vibe_pkg;

  localparam int RegW = 32;
  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_SAMPLES      = 3'd2,
    REG_RADIUS       = 3'd3,
    REG_MIN_MATCHES  = 3'd4,
    REG_MAX_MISMATCH = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  localparam int InDataW = 88;
  localparam int OutDataW = 16;
  localparam logic [7:0] CountMax = 8'd255;
  localparam logic [7:0] AbsorbLimit = 8'd2;

  localparam logic signed [1:0] NbrOffset [9] = '{
    -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd0
  };

  function automatic logic signed [1:0] pick_offset(input logic [3:0] pick);
    logic signed [1:0] off;
    off = 2'sd0;
    if (pick < 4'd9) off = NbrOffset[pick];
    return off;
  endfunction

endpackage

// ----- hw/rtl/vibe_pixel_classify_update.sv -----
// ----------------------------------------------------------------------------
// ViBe pixel classify and update
// Per-pixel background model held in a sample memory and a count memory.
// ----------------------------------------------------------------------------
// Flow: an input beat passes through CLAMP, ADDR, READ, CMP, CNT and DECIDE,
//   then NBR when a neighbor write is made, then OUT, which waits while output stalls.
// Items: a new item is not taken until the last one has been through the single
//   read-modify-write pass over the sample row memory and its second write for the neighbor.
// Reset: registers take their reset values; the count memory is then cleared
//   one entry a cycle over all MAX_WIDTH*MAX_HEIGHT entries, with s_tready low.
module vibe_pixel_classify_update #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 512,
  parameter int MAX_SAMPLES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pixel_x, pixel_y, pix_luma, sample_slot, subsample_draw,
  // neighbor_x_pick, neighbor_y_pick, refill_slots
  input  logic [vibe_pkg::InDataW-1:0]  s_tdata,
  // operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // foreground, mismatch_count
  output logic [vibe_pkg::OutDataW-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vibe_pkg::AddrW-1:0]    paddr,
  input  logic [vibe_pkg::RegW-1:0]     pwdata,
  output logic [vibe_pkg::RegW-1:0]     prdata,
  output logic                          pready
);
  import vibe_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(Depth);
  localparam int SW = $clog2(MAX_SAMPLES + 1);
  localparam int RowW = MAX_SAMPLES * 8;
  localparam int Lanes = 8;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CLAMP, ST_ADDR, ST_READ, ST_CMP, ST_CNT,
    ST_DECIDE, ST_NBR, ST_OUT
  } state_t;

  state_t state;

  logic [10:0] frame_width;
  logic [9:0]  frame_height;
  logic [5:0]  samples_in_use;
  logic [7:0]  match_radius;
  logic [2:0]  min_matches;
  logic [7:0]  max_mismatch;

  logic        op;
  logic [9:0]  in_x;
  logic [8:0]  in_y;
  logic [7:0]  pix_luma;
  logic [4:0]  sample_slot;
  logic [7:0]  subsample_draw;
  logic [3:0]  xpick, ypick;
  logic [34:0] refill_slots;

  logic [15:0] px, py, nx, ny;
  logic [AW-1:0] addr, naddr, clr_addr;
  logic [SW-1:0] s_eff;
  logic [RowW-1:0] row;
  logic [7:0] cnt_rd;
  logic [MAX_SAMPLES-1:0] mvec;
  logic [SW-1:0] mcnt;
  logic [SW-1:0] rem [Lanes];
  logic [2:0] rem_step;
  logic absorb;
  logic fg;
  logic [7:0] cnt_out;

  logic [RowW-1:0] sample_mem [Depth];
  logic [7:0] count_mem [Depth];

  logic sm_we;
  logic [AW-1:0] sm_addr;
  logic [MAX_SAMPLES-1:0] sm_be;
  logic cm_we;
  logic [AW-1:0] cm_addr;
  logic [7:0] cm_data;

  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_FRAME_WIDTH:  prdata = RegW'(frame_width);
      REG_FRAME_HEIGHT: prdata = RegW'(frame_height);
      REG_SAMPLES:      prdata = RegW'(samples_in_use);
      REG_RADIUS:       prdata = RegW'(match_radius);
      REG_MIN_MATCHES:  prdata = RegW'(min_matches);
      REG_MAX_MISMATCH: prdata = RegW'(max_mismatch);
      default:          prdata = '0;
    endcase
  end

  // effective frame size and sample count
  logic [15:0] w_eff, h_eff;
  always_comb begin
    w_eff = 16'(frame_width);
    if (frame_width == 11'd0) w_eff = 16'd1;
    else if (16'(frame_width) > 16'(MAX_WIDTH)) w_eff = 16'(MAX_WIDTH);
    h_eff = 16'(frame_height);
    if (frame_height == 10'd0) h_eff = 16'd1;
    else if (16'(frame_height) > 16'(MAX_HEIGHT)) h_eff = 16'(MAX_HEIGHT);
    s_eff = SW'(samples_in_use);
    if (16'(samples_in_use) > 16'(MAX_SAMPLES)) s_eff = SW'(MAX_SAMPLES);
  end

  logic [15:0] xc, yc, nxc, nyc;
  logic signed [1:0] xoff, yoff;
  always_comb begin
    xc = (16'(in_x) >= w_eff) ? w_eff - 16'd1 : 16'(in_x);
    yc = (16'(in_y) >= h_eff) ? h_eff - 16'd1 : 16'(in_y);
    xoff = pick_offset(xpick);
    yoff = pick_offset(ypick);
    nxc = xc;
    if (xoff < 0) nxc = (xc == 16'd0) ? xc : xc - 16'd1;
    else if (xoff > 0) nxc = (xc + 16'd1 >= w_eff) ? xc : xc + 16'd1;
    nyc = yc;
    if (yoff < 0) nyc = (yc == 16'd0) ? yc : yc - 16'd1;
    else if (yoff > 0) nyc = (yc + 16'd1 >= h_eff) ? yc : yc + 16'd1;
  end

  logic [MAX_SAMPLES-1:0] mvec_next;
  logic [SW-1:0] mcnt_next;
  always_comb begin
    mvec_next = '0;
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      logic [7:0] sv, d;
      sv = row[k*8 +: 8];
      d = (sv > pix_luma) ? sv - pix_luma : pix_luma - sv;
      mvec_next[k] = (SW'(k) < s_eff) && (d < match_radius);
    end
    mcnt_next = '0;
    for (int k = 0; k < MAX_SAMPLES; k++) mcnt_next = mcnt_next + SW'(mvec[k]);
  end

  // decision
  logic matched, refill;
  logic [7:0] cnt_inc, cnt_new;
  logic fg_new, absorb_new;
  logic [MAX_SAMPLES-1:0] be_pix, be_slot;
  always_comb begin
    matched = (SW'(min_matches) <= mcnt) || (min_matches == 3'd0);
    cnt_inc = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + 8'd1;
    refill = !matched && (cnt_inc > max_mismatch);
    absorb_new = matched && (subsample_draw < AbsorbLimit) && (s_eff != '0);
    be_slot = '0;
    be_pix = '0;
    for (int k = 0; k < MAX_SAMPLES; k++) begin
      be_slot[k] = (rem[0] == SW'(k));
      for (int j = 1; j < Lanes; j++) begin
        if (refill && (s_eff != '0) && (3'(j - 1) < min_matches) && (rem[j] == SW'(k)))
          be_pix[k] = 1'b1;
      end
    end
    if (op == OP_WRITE) begin
      fg_new = 1'b0;
      cnt_new = cnt_rd;
      be_pix = '0;
      for (int k = 0; k < MAX_SAMPLES; k++) be_pix[k] = (6'(sample_slot) == 6'(k));
    end else if (matched) begin
      fg_new = 1'b0;
      cnt_new = 8'd0;
      if (absorb_new) be_pix = be_slot;
    end else if (refill) begin
      fg_new = 1'b0;
      cnt_new = 8'd0;
    end else begin
      fg_new = 1'b1;
      cnt_new = cnt_inc;
    end
  end

  always_comb begin
    sm_we = 1'b0;
    sm_addr = addr;
    sm_be = be_pix;
    cm_we = 1'b0;
    cm_addr = addr;
    cm_data = cnt_new;
    case (state)
      ST_CLEAR: begin
        cm_we = 1'b1;
        cm_addr = clr_addr;
        cm_data = 8'd0;
      end
      ST_DECIDE: begin
        sm_we = 1'b1;
        cm_we = (op == OP_CLASSIFY);
      end
      ST_NBR: begin
        sm_we = 1'b1;
        sm_addr = naddr;
        sm_be = be_slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      for (int k = 0; k < MAX_SAMPLES; k++) begin
        if (sm_be[k]) sample_mem[sm_addr][k*8 +: 8] <= pix_luma;
      end
    end
    if (state == ST_READ) row <= sample_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) count_mem[cm_addr] <= cm_data;
    if (state == ST_READ) cnt_rd <= count_mem[addr];
  end

  // slot remainders, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rem_step <= 3'd0;
      for (int j = 0; j < Lanes; j++) rem[j] <= '0;
    end else if (rem_step < 3'd5) begin
      rem_step <= rem_step + 3'd1;
      for (int j = 0; j < Lanes; j++) begin
        logic [4:0] v;
        logic [SW:0] t;
        v = (j == 0) ? sample_slot : refill_slots[(j-1)*5 +: 5];
        t = {rem[j], v[3'd4 - rem_step]};
        if (t >= {1'b0, s_eff}) t = t - {1'b0, s_eff};
        rem[j] <= t[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      frame_width <= 11'd640;
      frame_height <= 10'd480;
      samples_in_use <= 6'd20;
      match_radius <= 8'd20;
      min_matches <= 3'd2;
      max_mismatch <= 8'd50;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_FRAME_WIDTH:  frame_width <= pwdata[10:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[9:0];
          REG_SAMPLES:      samples_in_use <= pwdata[5:0];
          REG_RADIUS:       match_radius <= pwdata[7:0];
          REG_MIN_MATCHES:  min_matches <= pwdata[2:0];
          REG_MAX_MISMATCH: max_mismatch <= pwdata[7:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(Depth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            in_x <= s_tdata[9:0];
            in_y <= s_tdata[18:10];
            pix_luma <= s_tdata[26:19];
            sample_slot <= s_tdata[31:27];
            subsample_draw <= s_tdata[39:32];
            xpick <= s_tdata[43:40];
            ypick <= s_tdata[47:44];
            refill_slots <= s_tdata[82:48];
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          px <= xc;
          py <= yc;
          nx <= nxc;
          ny <= nyc;
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          addr <= AW'(py) * AW'(MAX_WIDTH) + AW'(px);
          naddr <= AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);
          state <= ST_READ;
        end
        ST_READ: state <= ST_CMP;
        ST_CMP: begin
          mvec <= mvec_next;
          state <= ST_CNT;
        end
        ST_CNT: begin
          mcnt <= mcnt_next;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          fg <= fg_new;
          cnt_out <= cnt_new;
          absorb <= (op == OP_CLASSIFY) && absorb_new;
          state <= ((op == OP_CLASSIFY) && absorb_new) ? ST_NBR : ST_OUT;
        end
        ST_NBR: state <= ST_OUT;
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {7'd0, cnt_out, fg};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready) else $error("input taken during clear");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("second item taken");
  a_count_wr: assert property (@(posedge clk) disable iff (rst)
    cm_we |-> (state == ST_DECIDE || state == ST_CLEAR)) else $error("stray count write");
  a_nbr_only_absorb: assert property (@(posedge clk) disable iff (rst)
    state == ST_NBR |-> absorb && fg == 1'b0) else $error("neighbor write without absorb");

endmodule
